[design/sarp_pkg.sv]
// Shared types, constants and helpers for the servo angle ramp unit.
// No dependencies; imported by every module of the block.
package sarp_pkg;

  localparam int PULSE_BITS      = 24;
  localparam int STEP_COUNT_BITS = 20;
  localparam int ANG_W           = 18;
  localparam int CEIL_W          = 17;
  localparam int IVL_W           = 10;
  localparam int SPEED_W         = 24;
  localparam int CMD_W           = 2;
  localparam int CFG_W           = 24;
  localparam int CFG_IDX_W       = 3;

  // Divider: signed numerator, signed divisor, floor quotient.
  localparam int DIV_N   = 48;
  localparam int DIV_D   = 26;
  localparam int DIV_C_W = $clog2(DIV_N);
  localparam int MUL_A   = 26;
  localparam int MUL_B   = 21;

  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 3'd4;

  localparam logic [PULSE_BITS-1:0] PULSE_MIN_RST   = 24'd1000;
  localparam logic [PULSE_BITS-1:0] PULSE_MAX_RST   = 24'd2000;
  localparam logic [PULSE_BITS-1:0] LAST_PULSE_RST  = 24'd1500;
  localparam logic [ANG_W-1:0]      ANGLE_FLOOR_RST = 18'h3A600;  // -23040
  localparam logic [CEIL_W-1:0]     ANGLE_CEIL_RST  = 17'd23040;
  localparam logic [IVL_W-1:0]      INTERVAL_RST    = 10'd10;
  localparam logic [IVL_W-1:0]      INTERVAL_DFLT   = 10'd10;
  localparam logic [19:0]           HALF_DEGREE     = 20'd128;
  localparam logic [STEP_COUNT_BITS-1:0] STEP_MAX   = {{(STEP_COUNT_BITS-1){1'b1}}, 1'b0};

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_DIV_CUR   = 4'd1;
  localparam logic [3:0] OP_SET_CUR   = 4'd2;
  localparam logic [3:0] OP_DIV_MS    = 4'd3;
  localparam logic [3:0] OP_DIV_STEPS = 4'd4;
  localparam logic [3:0] OP_SET_PLAN  = 4'd5;
  localparam logic [3:0] OP_DIV_RAMP  = 4'd6;
  localparam logic [3:0] OP_SET_RAMP  = 4'd7;
  localparam logic [3:0] OP_SET_JUMP  = 4'd8;
  localparam logic [3:0] OP_SET_FINAL = 4'd9;
  localparam logic [3:0] OP_DIV_PULSE = 4'd10;
  localparam logic [3:0] OP_EMIT      = 4'd11;

  typedef struct packed {
    logic       accept;
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic jump;
    logic step_over;
    logic busy;
    logic out_free;
  } dp_status_t;

  // Clamp up to the floor first, then down to the ceiling.
  function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [21:0] a,
                                                        input logic signed [ANG_W-1:0] lo,
                                                        input logic [CEIL_W-1:0] hi);
    logic signed [21:0] t;
    logic signed [21:0] lo_x;
    logic signed [21:0] hi_x;
    lo_x = {{(22-ANG_W){lo[ANG_W-1]}}, lo};
    hi_x = {{(22-CEIL_W){1'b0}}, hi};
    t = a;
    if (t < lo_x) t = lo_x;
    if (t > hi_x) t = hi_x;
    return t[ANG_W-1:0];
  endfunction

endpackage

[design/sarp_div.sv]
// Iterative signed floor divider, one quotient bit per cycle.
// Depends on sarp_pkg.
module sarp_div import sarp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_N-1:0] num,
  input  logic signed [DIV_D-1:0] den,
  output logic signed [DIV_N-1:0] q,
  output logic                    done
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_PREP = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;
  localparam logic [1:0] D_FIX  = 2'd3;

  logic [1:0]              state;
  logic [DIV_C_W-1:0]      cnt;
  logic signed [DIV_N-1:0] num_r;
  logic signed [DIV_D-1:0] den_r;
  logic                    neg;
  logic [DIV_N-1:0]        mag;
  logic [DIV_D-1:0]        dabs;
  logic [DIV_D-1:0]        rem;
  logic [DIV_D:0]          rem_sh;
  logic                    fit;

  assign rem_sh = {rem, mag[DIV_N-1]};
  assign fit    = rem_sh >= {1'b0, dabs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            num_r <= num;
            den_r <= den;
            state <= D_PREP;
          end
        end
        D_PREP: begin
          neg   <= num_r[DIV_N-1] ^ den_r[DIV_D-1];
          mag   <= num_r[DIV_N-1] ? DIV_N'(-num_r) : num_r;
          dabs  <= den_r[DIV_D-1] ? DIV_D'(-den_r) : den_r;
          rem   <= '0;
          cnt   <= '0;
          state <= D_RUN;
        end
        D_RUN: begin
          // quotient bits shift into the low end of mag
          if (fit) begin
            rem <= DIV_D'(rem_sh - {1'b0, dabs});
          end else begin
            rem <= rem_sh[DIV_D-1:0];
          end
          mag <= {mag[DIV_N-2:0], fit};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_C_W'(DIV_N - 1)) state <= D_FIX;
        end
        D_FIX: begin
          if (neg) begin
            q <= -$signed(mag + DIV_N'(rem != '0));
          end else begin
            q <= mag;
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

[design/sarp_datapath.sv]
// Datapath: configuration registers, move plan, shared multiplier and
// divider, and the output register. Depends on sarp_pkg and sarp_div.
module sarp_datapath import sarp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic [CMD_W-1:0]            command,
  input  logic signed [ANG_W-1:0]     target_angle,
  input  logic [SPEED_W-1:0]          speed,
  input  logic                        out_stall,
  input  dp_cmd_t                     ctl,
  output dp_status_t                  st,
  output logic                        out_valid,
  output logic [PULSE_BITS-1:0]       pulse_width,
  output logic signed [ANG_W-1:0]     angle,
  output logic [STEP_COUNT_BITS-1:0]  step_number,
  output logic                        last
);

  logic [PULSE_BITS-1:0]      pulse_min;
  logic [PULSE_BITS-1:0]      pulse_max;
  logic signed [ANG_W-1:0]    angle_floor;
  logic [CEIL_W-1:0]          angle_ceiling;
  logic [IVL_W-1:0]           step_interval;

  logic [PULSE_BITS-1:0]      last_pulse;
  logic signed [ANG_W-1:0]    tgt;
  logic [SPEED_W-1:0]         spd;
  logic signed [ANG_W-1:0]    move_target;
  logic signed [19:0]         cur;
  logic signed [19:0]         diff;
  logic signed [19:0]         start_angle;
  logic signed [19:0]         move_diff;
  logic [STEP_COUNT_BITS-1:0] total_steps;
  logic [STEP_COUNT_BITS-1:0] step_count;
  logic                       busy;
  logic signed [ANG_W-1:0]    ang;
  logic [STEP_COUNT_BITS-1:0] idx;
  logic                       fin;

  logic signed [19:0]         span;
  logic signed [24:0]         dp;
  logic [PULSE_BITS-1:0]      pclamp;
  logic [19:0]                mag;
  logic [IVL_W-1:0]           iv;
  logic signed [MUL_A-1:0]    mul_a;
  logic signed [MUL_B-1:0]    mul_b;
  logic signed [MUL_A+MUL_B-1:0] prod;
  logic signed [DIV_N-1:0]    div_num;
  logic signed [DIV_D-1:0]    div_den;
  logic                       div_start;
  logic signed [DIV_N-1:0]    q;
  logic                       div_done;
  logic signed [19:0]         floor_x;
  logic signed [19:0]         cur_v;
  logic signed [19:0]         diff_v;
  logic [STEP_COUNT_BITS-1:0] steps_v;
  logic                       out_free;

  assign floor_x = {{2{angle_floor[ANG_W-1]}}, angle_floor};
  assign span    = $signed({3'b0, angle_ceiling}) - floor_x;
  assign dp      = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
  assign mag     = diff[19] ? 20'(-diff) : diff;
  assign iv      = (step_interval == '0) ? INTERVAL_DFLT : step_interval;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    pclamp = last_pulse;
    if (pclamp < pulse_min) pclamp = pulse_min;
    if (pclamp > pulse_max) pclamp = pulse_max;
  end

  // operand selection for the shared multiplier and divider
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_den = '0;
    case (ctl.op)
      OP_DIV_CUR: begin
        mul_a   = $signed({2'b0, pclamp}) - $signed({2'b0, pulse_min});
        mul_b   = {span[19], span};
        div_den = {dp[24], dp};
      end
      OP_DIV_MS: begin
        mul_a   = {6'b0, mag};
        mul_b   = 21'sd1000;
        div_den = {2'b0, spd};
      end
      OP_DIV_STEPS: begin
        div_den = {{(DIV_D-IVL_W){1'b0}}, iv};
      end
      OP_DIV_RAMP: begin
        mul_a   = {{6{move_diff[19]}}, move_diff};
        mul_b   = {1'b0, step_count};
        div_den = {{(DIV_D-STEP_COUNT_BITS){1'b0}}, total_steps};
      end
      OP_DIV_PULSE: begin
        mul_a   = {dp[24], dp};
        mul_b   = $signed({{3{ang[ANG_W-1]}}, ang}) - $signed({{3{angle_floor[ANG_W-1]}},
                  angle_floor});
        div_den = {{6{span[19]}}, span};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign div_num   = (ctl.op == OP_DIV_STEPS) ? q : {prod[MUL_A+MUL_B-1], prod};
  assign div_start = (ctl.op == OP_DIV_CUR) || (ctl.op == OP_DIV_MS) ||
                     (ctl.op == OP_DIV_STEPS) || (ctl.op == OP_DIV_RAMP) ||
                     (ctl.op == OP_DIV_PULSE);

  sarp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .q     (q),
    .done  (div_done)
  );

  assign cur_v  = (dp == '0) ? floor_x : floor_x + q[19:0];
  assign diff_v = {{2{tgt[ANG_W-1]}}, tgt} - cur_v;

  always_comb begin
    steps_v = q[STEP_COUNT_BITS-1:0];
    if (q == '0) steps_v = STEP_COUNT_BITS'(1);
    else if (q > $signed({{(DIV_N-STEP_COUNT_BITS){1'b0}}, STEP_MAX})) steps_v = STEP_MAX;
  end

  assign st.div_done  = div_done;
  assign st.jump      = (spd == '0) || (mag < HALF_DEGREE);
  assign st.step_over = step_count > total_steps;
  assign st.busy      = busy;
  assign st.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min     <= PULSE_MIN_RST;
      pulse_max     <= PULSE_MAX_RST;
      angle_floor   <= ANGLE_FLOOR_RST;
      angle_ceiling <= ANGLE_CEIL_RST;
      step_interval <= INTERVAL_RST;
      last_pulse    <= LAST_PULSE_RST;
      move_target   <= '0;
      start_angle   <= '0;
      move_diff     <= '0;
      total_steps   <= '0;
      step_count    <= '0;
      busy          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PULSE_MIN:     pulse_min     <= cfg_data[PULSE_BITS-1:0];
          REG_PULSE_MAX:     pulse_max     <= cfg_data[PULSE_BITS-1:0];
          REG_ANGLE_FLOOR:   angle_floor   <= cfg_data[ANG_W-1:0];
          REG_ANGLE_CEILING: angle_ceiling <= cfg_data[CEIL_W-1:0];
          REG_STEP_INTERVAL: step_interval <= cfg_data[IVL_W-1:0];
          default: begin
          end
        endcase
      end

      if (ctl.op == OP_EMIT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (ctl.accept) begin
        tgt <= target_angle;
        spd <= speed;
        case (command)
          CMD_MOVE: begin
            busy        <= 1'b0;
            move_target <= target_angle;
          end
          CMD_TICK: begin
            if (busy) step_count <= step_count + 1'b1;
          end
          CMD_CANCEL: busy <= 1'b0;
          default: begin
          end
        endcase
      end

      case (ctl.op)
        OP_SET_CUR: begin
          cur  <= cur_v;
          diff <= diff_v;
        end
        OP_SET_PLAN: begin
          total_steps <= steps_v;
          start_angle <= cur;
          move_diff   <= diff;
          step_count  <= STEP_COUNT_BITS'(1);
          busy        <= 1'b1;
        end
        OP_SET_RAMP: begin
          ang <= clamp_ang({{2{start_angle[19]}}, start_angle} + q[21:0], angle_floor,
                           angle_ceiling);
          idx <= step_count;
          fin <= 1'b0;
        end
        OP_SET_JUMP: begin
          ang <= clamp_ang({{4{move_target[ANG_W-1]}}, move_target}, angle_floor,
                           angle_ceiling);
          idx <= '0;
          fin <= 1'b1;
        end
        OP_SET_FINAL: begin
          ang  <= clamp_ang({{4{move_target[ANG_W-1]}}, move_target}, angle_floor,
                            angle_ceiling);
          idx  <= total_steps + 1'b1;
          fin  <= 1'b1;
          busy <= 1'b0;
        end
        OP_EMIT: begin
          // a span of zero or less maps every angle to pulse_min
          if (span <= 0) begin
            last_pulse  <= pulse_min;
            pulse_width <= pulse_min;
          end else begin
            last_pulse  <= pulse_min + q[PULSE_BITS-1:0];
            pulse_width <= pulse_min + q[PULSE_BITS-1:0];
          end
          angle       <= ang;
          step_number <= idx;
          last        <= fin;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/sarp_ctrl.sv]
// Controller: sequences the datapath through readback, planning, step
// angle and pulse conversion. Depends on sarp_pkg.
module sarp_ctrl import sarp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  input  dp_status_t       st,
  output logic             in_stall,
  output dp_cmd_t          ctl
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV_CUR   = 4'd1;
  localparam logic [3:0] S_WAIT      = 4'd2;
  localparam logic [3:0] S_SET_CUR   = 4'd3;
  localparam logic [3:0] S_JCHK      = 4'd4;
  localparam logic [3:0] S_DIV_MS    = 4'd5;
  localparam logic [3:0] S_DIV_STEPS = 4'd6;
  localparam logic [3:0] S_SET_PLAN  = 4'd7;
  localparam logic [3:0] S_TCHK      = 4'd8;
  localparam logic [3:0] S_DIV_RAMP  = 4'd9;
  localparam logic [3:0] S_SET_RAMP  = 4'd10;
  localparam logic [3:0] S_SET_JUMP  = 4'd11;
  localparam logic [3:0] S_SET_FINAL = 4'd12;
  localparam logic [3:0] S_DIV_PULSE = 4'd13;
  localparam logic [3:0] S_EMIT      = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] ret;
  logic [3:0] ret_next;
  logic [3:0] op;

  assign in_stall   = state != S_IDLE;
  assign ctl.accept = in_valid && (state == S_IDLE);
  assign ctl.op     = op;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_MOVE) state_next = S_DIV_CUR;
          else if (command == CMD_TICK && st.busy) state_next = S_TCHK;
        end
      end
      S_DIV_CUR: begin
        op = OP_DIV_CUR;
        ret_next = S_SET_CUR;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (st.div_done) state_next = ret;
      end
      S_SET_CUR: begin
        op = OP_SET_CUR;
        state_next = S_JCHK;
      end
      S_JCHK: state_next = st.jump ? S_SET_JUMP : S_DIV_MS;
      S_DIV_MS: begin
        op = OP_DIV_MS;
        ret_next = S_DIV_STEPS;
        state_next = S_WAIT;
      end
      S_DIV_STEPS: begin
        op = OP_DIV_STEPS;
        ret_next = S_SET_PLAN;
        state_next = S_WAIT;
      end
      S_SET_PLAN: begin
        op = OP_SET_PLAN;
        state_next = S_DIV_RAMP;
      end
      S_TCHK: state_next = st.step_over ? S_SET_FINAL : S_DIV_RAMP;
      S_DIV_RAMP: begin
        op = OP_DIV_RAMP;
        ret_next = S_SET_RAMP;
        state_next = S_WAIT;
      end
      S_SET_RAMP: begin
        op = OP_SET_RAMP;
        state_next = S_DIV_PULSE;
      end
      S_SET_JUMP: begin
        op = OP_SET_JUMP;
        state_next = S_DIV_PULSE;
      end
      S_SET_FINAL: begin
        op = OP_SET_FINAL;
        state_next = S_DIV_PULSE;
      end
      S_DIV_PULSE: begin
        op = OP_DIV_PULSE;
        ret_next = S_EMIT;
        state_next = S_WAIT;
      end
      S_EMIT: begin
        // hold until the output register can take the item
        if (st.out_free) begin
          op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

[design/servo_angle_ramp_to_pulse_width_unit.sv]
// Top level of the servo angle ramp unit: controller plus datapath.
// Depends on sarp_pkg, sarp_ctrl, sarp_datapath.
//
// Input channel (in_valid/in_stall) takes move, tick and cancel items; the
// output channel (out_valid/out_stall) returns at most one pulse width item
// per input. A move reads the angle back from the last pulse width, plans a
// linear ramp and emits its first step, or at zero speed or a distance under
// 128 emits the target at once; each tick emits the next step, and a final
// item carries the exact target. Cancel, unknown commands and idle ticks emit
// none. One item is worked at a time; in_stall is high from acceptance until
// its result is loaded into the output register. Every division runs through
// one shared bit-serial divider: ramping move, 5 divisions; jump move, 2;
// ramp tick, 2; final tick of a ramp, 1; cancel or tick while idle, none.
// A stalled output holds its item; the next result waits in the controller
// until the output register frees, so nothing is dropped.
// Reset (rst, synchronous) restores the register defaults, a last pulse width
// of 1500 and an idle plan. Configuration writes are taken on any cycle and
// apply to later computations.
module servo_angle_ramp_to_pulse_width_unit import sarp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [CMD_W-1:0]            command,
  input  logic signed [ANG_W-1:0]     target_angle,
  input  logic [SPEED_W-1:0]          speed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [PULSE_BITS-1:0]       pulse_width,
  output logic signed [ANG_W-1:0]     angle,
  output logic [STEP_COUNT_BITS-1:0]  step_number,
  output logic                        last
);

  dp_cmd_t    ctl;
  dp_status_t st;

  sarp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .st       (st),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  sarp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .target_angle (target_angle),
    .speed        (speed),
    .out_stall    (out_stall),
    .ctl          (ctl),
    .st           (st),
    .out_valid    (out_valid),
    .pulse_width  (pulse_width),
    .angle        (angle),
    .step_number  (step_number),
    .last         (last)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for servo_angle_ramp_to_pulse_width_unit.
// Needs sarp_pkg and the unit. Holds its own model of the ramp planner
// and checks every output item, field by field, against it or against the value given in a directed row.
module testbench import sarp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [PULSE_BITS-1:0]      pw;
    logic [ANG_W-1:0]           ang;
    logic [STEP_COUNT_BITS-1:0] stp;
    logic                       fin;
  } pulse_item_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    longint           tgt;
    longint           spd;
    bit               typed;
    pulse_item_t      want;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [CMD_W-1:0] command = CMD_TICK;
  logic signed [ANG_W-1:0] target_angle = '0;
  logic [SPEED_W-1:0] speed = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [PULSE_BITS-1:0] pulse_width;
  logic signed [ANG_W-1:0] angle;
  logic [STEP_COUNT_BITS-1:0] step_number;
  logic last;

  servo_angle_ramp_to_pulse_width_unit u_top (.*);

  always #1 clk = ~clk;

  // Model state
  longint m_pmin = 1000, m_pmax = 2000, m_floor = -23040, m_ceil = 23040, m_ivl = 10;
  longint m_last_pulse = 1500, m_start = 0, m_diff = 0, m_target = 0;
  longint m_total = 0, m_count = 0;
  bit     m_busy = 0;

  pulse_item_t pending_pulses[$];
  int errors = 0, items_sent = 0, results_seen = 0, ramp_finals = 0;
  bit quiet = 0;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if (n % d < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_deg(longint a);
    if (a < m_floor) a = m_floor;
    if (a > m_ceil) a = m_ceil;
    return a;
  endfunction

  function automatic longint pulse_from_angle(longint a);
    longint span, dp;
    span = m_ceil - m_floor;
    dp = m_pmax - m_pmin;
    a = clamp_deg(a);
    if (span <= 0) return m_pmin;
    return (m_pmin + floor_div((a - m_floor) * dp, span)) & 64'hFFFFFF;
  endfunction

  function automatic longint angle_from_pulse(longint p);
    longint dp;
    dp = m_pmax - m_pmin;
    if (p < m_pmin) p = m_pmin;
    if (p > m_pmax) p = m_pmax;
    if (dp == 0) return m_floor;
    return m_floor + floor_div((p - m_pmin) * (m_ceil - m_floor), dp);
  endfunction

  function automatic pulse_item_t make_pulse(longint a, longint idx, bit fin);
    pulse_item_t r;
    a = clamp_deg(a);
    m_last_pulse = pulse_from_angle(a);
    r.pw = m_last_pulse[PULSE_BITS-1:0];
    r.ang = a[ANG_W-1:0];
    r.stp = idx[STEP_COUNT_BITS-1:0];
    r.fin = fin;
    return r;
  endfunction

  function automatic bit predict_ramp(logic [CMD_W-1:0] cmd, longint tgt, longint spd,
                                      output pulse_item_t r);
    longint cur, dif, mag, iv, steps;
    r = '0;
    case (cmd)
      CMD_MOVE: begin
        m_busy = 0;
        m_target = tgt;
        cur = angle_from_pulse(m_last_pulse);
        dif = tgt - cur;
        mag = dif < 0 ? -dif : dif;
        if (spd == 0 || mag < 128) begin
          r = make_pulse(tgt, 0, 1);
          return 1;
        end
        iv = m_ivl == 0 ? 10 : m_ivl;
        steps = ((mag * 1000) / spd) / iv;
        if (steps < 1) steps = 1;
        if (steps > (1 << STEP_COUNT_BITS) - 2) steps = (1 << STEP_COUNT_BITS) - 2;
        m_start = cur;
        m_diff = dif;
        m_total = steps;
        m_count = 1;
        m_busy = 1;
        r = make_pulse(cur + floor_div(dif, steps), 1, 0);
        return 1;
      end
      CMD_TICK: begin
        if (!m_busy) return 0;
        m_count++;
        if (m_count <= m_total) begin
          r = make_pulse(m_start + floor_div(m_diff * m_count, m_total), m_count, 0);
          return 1;
        end
        m_busy = 0;
        r = make_pulse(m_target, m_total + 1, 1);
        return 1;
      end
      CMD_CANCEL: m_busy = 0;
      default: ;
    endcase
    return 0;
  endfunction

  // Output side: random stall bursts, check against the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    pulse_item_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (last && step_number != 0) ramp_finals++;
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected item pw=%0d angle=%0d step=%0d last=%0b",
                 $realtime, pulse_width, angle, step_number, last);
        errors++;
      end else begin
        e = pending_pulses.pop_front();
        if (pulse_width !== e.pw) begin
          $display("%0t: pulse_width expected %0d actual %0d", $realtime, e.pw, pulse_width);
          errors++;
        end
        if (angle !== e.ang) begin
          $display("%0t: angle expected %0d actual %0d", $realtime,
                   $signed(e.ang), angle);
          errors++;
        end
        if (step_number !== e.stp) begin
          $display("%0t: step_number expected %0d actual %0d", $realtime, e.stp,
                   step_number);
          errors++;
        end
        if (last !== e.fin) begin
          $display("%0t: last expected %0b actual %0b", $realtime, e.fin, last);
          errors++;
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the item is taken, or after a random idle gap that follows it.
  task automatic send_item(logic [CMD_W-1:0] cmd, longint tgt, longint spd,
                           bit typed = 0, pulse_item_t want = '0);
    pulse_item_t r;
    bit got;
    in_valid <= 1;
    command <= cmd;
    target_angle <= tgt[ANG_W-1:0];
    speed <= spd[SPEED_W-1:0];
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    got = predict_ramp(cmd, tgt, spd, r);
    if (typed) r = want;
    if (got || typed) pending_pulses.push_back(r);
    items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Wait out every expected item, then keep idling before returning.
  task automatic drain;
    in_valid <= 0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_regs(longint pmin, longint pmax, longint flo, longint cei,
                            longint ivl);
    longint v[5];
    v = '{pmin, pmax, flo, cei, ivl};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= v[i][CFG_W-1:0];
      @(posedge clk);
    end
    cfg_write <= 0;
    m_pmin = pmin & 64'hFFFFFF;
    m_pmax = pmax & 64'hFFFFFF;
    m_floor = longint'($signed(flo[ANG_W-1:0]));
    m_ceil = cei & 64'h1FFFF;
    m_ivl = ivl & 64'h3FF;
  endtask

  function automatic longint rand_angle();
    return longint'($urandom_range(0, 184320)) - 92160;
  endfunction

  // Move planned for about k steps, then its ticks; sometimes cut short.
  task automatic ramp_sequence;
    longint tgt, cur, mag, iv, spd;
    int k;
    tgt = ($urandom_range(0, 3) == 0) ? rand_angle() :
          longint'($urandom_range(0, 2 * m_ceil + 512)) + m_floor - 256;
    cur = angle_from_pulse(m_last_pulse);
    mag = tgt > cur ? tgt - cur : cur - tgt;
    iv = m_ivl == 0 ? 10 : m_ivl;
    k = $urandom_range(1, 8);
    spd = (mag * 1000) / (k * iv);
    if (spd < 1) spd = 1;
    if (spd > 24'hFFFFFF) spd = 24'hFFFFFF;
    send_item(CMD_MOVE, tgt, spd);
    for (int i = 0; i < k + 1 + $urandom_range(0, 1); i++) begin
      case ($urandom_range(0, 19))
        0: send_item(CMD_CANCEL, rand_angle(), $urandom);
        1: send_item(CMD_MOVE, rand_angle(), $urandom_range(1, 24'hFFFFFF));
        default: send_item(CMD_TICK, rand_angle(), $urandom);
      endcase
    end
  endtask

  task automatic noise_item;
    longint spd;
    spd = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom & 32'hFFFFFF);
    send_item(CMD_W'($urandom_range(0, 3)), rand_angle(), spd);
  endtask

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [CMD_W-1:0] c, longint t, longint s,
                                    bit ty = 0, longint pw = 0, longint a = 0,
                                    longint st = 0, bit f = 0);
    stim_row_t r;
    r.cmd = c;
    r.tgt = t;
    r.spd = s;
    r.typed = ty;
    r.want.pw = pw[PULSE_BITS-1:0];
    r.want.ang = a[ANG_W-1:0];
    r.want.stp = st[STEP_COUNT_BITS-1:0];
    r.want.fin = f;
    return r;
  endfunction

  initial begin
    int phase_items;
    // Jumps with values readable from the reset registers, then ramps.
    directed = '{
      row(CMD_MOVE, 0, 0, 1, 1500, 0, 0, 1),
      row(CMD_MOVE, 23040, 0, 1, 2000, 23040, 0, 1),
      row(CMD_MOVE, -92160, 0, 1, 1000, -23040, 0, 1),
      row(CMD_MOVE, 92160, 0, 1, 2000, 23040, 0, 1),
      row(CMD_MOVE, 23167, 5000, 1, 2000, 23040, 0, 1),
      row(CMD_TICK, 0, 0),
      row(CMD_CANCEL, 0, 0),
      row(CMD_UNKNOWN, -92160, 24'hFFFFFF),
      row(CMD_MOVE, 0, 2304000),
      row(CMD_TICK, 0, 0),
      row(CMD_TICK, 0, 0),
      row(CMD_MOVE, -23040, 230400),
      row(CMD_TICK, 0, 0),
      row(CMD_TICK, 0, 0),
      row(CMD_CANCEL, 0, 0),
      row(CMD_TICK, 0, 0),
      row(CMD_MOVE, 23040, 24'hFFFFFF),
      row(CMD_TICK, 0, 0),
      row(CMD_MOVE, -23040, 1),
      row(CMD_TICK, 0, 0),
      row(CMD_MOVE, 0, 100000),
      row(CMD_TICK, 92160, 24'hFFFFFF),
      row(CMD_TICK, -92160, 0),
      row(CMD_TICK, 0, 0),
      row(CMD_UNKNOWN, 92160, 0)
    };
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].tgt, directed[i].spd,
                directed[i].typed, directed[i].want);
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: write_regs(0, 24'hFFFFFF, -92160, 92160, 1000);
        1: write_regs(500, 2500, -23040, 23040, 1);
        2: write_regs(2000, 1000, -46080, 46080, 0);
        3: write_regs(1000, 1000, 0, 0, 20);
        4: write_regs($urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF,
                      -longint'($urandom_range(0, 92160)), $urandom_range(0, 92160),
                      $urandom_range(1, 1000));
        5: write_regs(24'hFFFFFF, 0, -92160, 0, 3);
        6: write_regs(1000, 2000, -23040, 23040, 5);
        default: begin
          write_regs(800, 2200, -34560, 34560, 10);
          quiet = 1;
        end
      endcase
      phase_items = 0;
      while (phase_items < 115) begin
        int start;
        start = items_sent;
        if ($urandom_range(0, 9) < 7) ramp_sequence();
        else noise_item();
        phase_items += items_sent - start;
      end
    end
    drain();
    $display("Sent %0d items over 9 register settings; checked %0d output items,",
             items_sent, results_seen);
    $display("%0d of them ramp final steps, with random stalls on both channels.",
             ramp_finals);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d items still expected", pending_pulses.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
